/* design/mas_pkg.sv */
// Package for the memory admission scheduler.
// Types, decision codes, cell commands and search token shared by all files.
// No dependencies.
package mas_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int MAX_STEPS_DEF = 64;
	localparam int ID_W          = 8;   // holds ids up to the largest task count
	localparam int SUM_W         = 36;
	localparam int THR_W         = 34;

	typedef enum logic [2:0] {
		DEC_CONT = 3'd0,
		DEC_SUSP = 3'd1,
		DEC_FIN  = 3'd2,
		DEC_PROF = 3'd3,
		DEC_IGN  = 3'd4
	} dec_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_CLEAR,
		OP_SETLD,
		OP_SUSPEND,
		OP_RELEASE
	} cell_op_t;

	typedef enum logic [1:0] {
		CFG_LIMIT  = 2'd0,
		CFG_LENGTH = 2'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD1,
		S_RD2,
		S_RD3,
		S_EVAL,
		S_RISE,
		S_SRCH,
		S_SET,
		S_DONE
	} state_t;

	typedef struct packed {
		cell_op_t          op;
		logic [ID_W-1:0]   id;
		logic [31:0]       val;
		logic [THR_W-1:0]  thr;
	} cell_cmd_t;

	typedef struct packed {
		logic              found;
		logic [THR_W-1:0]  thr;
		logic [ID_W-1:0]   id;
		logic [31:0]       load;
		logic [31:0]       lar;
	} token_t;

endpackage

/* design/mas_cell.sv */
// One task slot of the scheduler chain.
// Holds the task state and passes the release search token to its neighbor.
// Depends on mas_pkg.
module mas_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mas_pkg::cell_cmd_t cmd,
	input  logic [mas_pkg::SUM_W-1:0] usage,
	input  mas_pkg::token_t   tok_in,
	output mas_pkg::token_t   tok_out,
	output logic              reg_o,
	output logic              blk_o,
	output logic [31:0]       load_o
);
	import mas_pkg::*;

	logic              reg_q;
	logic              blk_q;
	logic [31:0]       load_q;
	logic [THR_W-1:0]  thr_q;
	logic [31:0]       lar_q;
	token_t            tok_q;
	logic              hit;
	logic              elig;
	logic              better;

	assign hit = (cmd.id == ID_W'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_q  <= 1'b0;
			blk_q  <= 1'b0;
			load_q <= '0;
		end else if (hit) begin
			unique case (cmd.op)
				OP_CLEAR: begin
					reg_q  <= 1'b0;
					load_q <= '0;
				end
				OP_SETLD: begin
					reg_q  <= 1'b1;
					load_q <= cmd.val;
				end
				OP_SUSPEND: begin
					blk_q <= 1'b1;
				end
				OP_RELEASE: begin
					blk_q  <= 1'b0;
					load_q <= lar_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hit && cmd.op == OP_SUSPEND) begin
			thr_q <= cmd.thr;
			lar_q <= cmd.val;
		end
	end

	// signed threshold against unsigned usage
	assign elig = blk_q &&
		($signed({{4{thr_q[THR_W-1]}}, thr_q}) > $signed({2'b00, usage}));
	assign better = elig && (!tok_in.found || ($signed(thr_q) < $signed(tok_in.thr)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (better) begin
			tok_q.found <= 1'b1;
			tok_q.thr   <= thr_q;
			tok_q.id    <= ID_W'(IDX);
			tok_q.load  <= load_q;
			tok_q.lar   <= lar_q;
		end else begin
			tok_q <= tok_in;
		end
	end

	assign tok_out = tok_q;
	assign reg_o   = reg_q;
	assign blk_o   = blk_q;
	assign load_o  = load_q;

endmodule

/* design/memory_admission_scheduler_unit.sv */
// Memory admission scheduler: control sequencer, profile memory, chain of task cells.
// A profile write goes straight to done; a measurement reads the profile, evaluates and
// ends if ignored; a rising step skips the search, and a last, flat or falling step
// runs the release search token along the chain. One item at a time; busy from
// accept to done. Async active-low reset clears task state, sum and registers; profile
// is undefined until written. The result receiver cannot stall; done pulses one cycle.
module memory_admission_scheduler_unit #(
	parameter int MAX_TASKS = mas_pkg::MAX_TASKS_DEF,
	parameter int MAX_STEPS = mas_pkg::MAX_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [3:0]  task_id,
	input  logic [5:0]  step,
	input  logic [31:0] amount,
	output logic        done,
	output logic [2:0]  decision,
	output logic        resume_valid,
	output logic [3:0]  resume_task,
	output logic [35:0] expected_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import mas_pkg::*;

	localparam int TW = $clog2(MAX_TASKS);
	localparam int AW = $clog2(MAX_STEPS);
	localparam int CW = $clog2(MAX_TASKS + 1);

	state_t            state_q, state_d;
	logic [31:0]       limit_q;
	logic [6:0]        plen_q;
	logic [31:0]       mem [MAX_STEPS];
	logic [31:0]       rdata_q;
	logic [AW-1:0]     raddr;
	logic [3:0]        tid_q;
	logic [5:0]        step_q;
	logic [31:0]       amount_q;
	logic [31:0]       cur_q, nxt_q;
	logic [32:0]       change_q;
	logic [SUM_W-1:0]  usage_q;
	logic [SUM_W-1:0]  sum_q;
	logic              set_en_q;
	logic [31:0]       set_val_q;
	logic [CW-1:0]     cnt_q;
	dec_t              dec_q;
	logic              rv_q;
	logic [3:0]        who_q;
	cell_cmd_t         cmd;
	token_t            tok [MAX_TASKS+1];
	logic              reg_v [MAX_TASKS];
	logic              blk_v [MAX_TASKS];
	logic [31:0]       load_a [MAX_TASKS];
	logic [TW-1:0]     tidx;
	logic              tid_bad;
	logic              tid_reg, tid_blk;
	logic [31:0]       tid_load;
	logic              others_blk;
	logic [15:0]       len_eff;
	logic              last_step;
	logic              rising;
	logic              over;
	logic [SUM_W-1:0]  usage_max;
	logic [SUM_W-1:0]  tid_load_x;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 32'hFFFF_FFFF;
			plen_q  <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LIMIT:  limit_q <= cfg_data;
				CFG_LENGTH: plen_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// profile memory
	always_ff @(posedge clk) begin
		if (start && !busy && !kind && 16'(step) < 16'(MAX_STEPS))
			mem[AW'(step)] <= amount;
		rdata_q <= mem[raddr];
	end

	assign raddr = (state_q == S_RD1) ? AW'(step_q) : AW'(7'(step_q) + 7'd1);

	// task chain
	assign tok[0] = '0;
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		mas_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.usage   (usage_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.reg_o   (reg_v[i]),
			.blk_o   (blk_v[i]),
			.load_o  (load_a[i])
		);
	end

	assign tidx     = TW'(tid_q);
	assign tid_bad  = 9'(tid_q) >= 9'(MAX_TASKS);
	assign tid_reg  = reg_v[tidx];
	assign tid_blk  = blk_v[tidx];
	assign tid_load = load_a[tidx];
	assign tid_load_x = tid_reg ? SUM_W'(tid_load) : '0;

	// every other registered task already blocked
	always_comb begin
		others_blk = 1'b1;
		for (int i = 0; i < MAX_TASKS; i++)
			if (TW'(i) != tidx && reg_v[i] && !blk_v[i])
				others_blk = 1'b0;
	end

	always_comb begin
		if (plen_q == 7'd0)
			len_eff = 16'd1;
		else if (16'(plen_q) > 16'(MAX_STEPS))
			len_eff = 16'(MAX_STEPS);
		else
			len_eff = 16'(plen_q);
	end
	assign last_step = (16'(step_q) + 16'd1) >= len_eff;
	assign usage_max = (SUM_W'(amount_q) > sum_q) ? SUM_W'(amount_q) : sum_q;
	assign rising    = !change_q[32] && (change_q != '0);
	assign over      = ({2'b00, usage_q} + {{5{change_q[32]}}, change_q})
		>= {6'b0, limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = kind ? S_RD1 : S_DONE;
			S_RD1:  state_d = S_RD2;
			S_RD2:  state_d = S_RD3;
			S_RD3:  state_d = S_EVAL;
			S_EVAL: begin
				if (tid_bad || tid_blk)
					state_d = S_DONE;
				else if (last_step)
					state_d = S_SRCH;
				else
					state_d = S_RISE;
			end
			S_RISE: state_d = rising ? S_SET : S_SRCH;
			S_SRCH: if (cnt_q == CW'(MAX_TASKS)) state_d = S_SET;
			S_SET:  state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// cell command from sequencer
	always_comb begin
		cmd     = '0;
		cmd.op  = OP_NOP;
		cmd.id  = ID_W'(tid_q);
		unique case (state_q)
			S_EVAL: if (!tid_bad && !tid_blk && last_step) cmd.op = OP_CLEAR;
			S_RISE: begin
				if (rising && over && !others_blk) begin
					cmd.op  = OP_SUSPEND;
					cmd.val = nxt_q;
					cmd.thr = {2'b00, limit_q} - {change_q[32], change_q};
				end
			end
			S_SRCH: begin
				if (cnt_q == CW'(MAX_TASKS) && tok[MAX_TASKS].found) begin
					cmd.op = OP_RELEASE;
					cmd.id = tok[MAX_TASKS].id;
				end
			end
			S_SET: begin
				if (set_en_q) begin
					cmd.op  = OP_SETLD;
					cmd.val = set_val_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			cnt_q    <= '0;
			dec_q    <= DEC_CONT;
			rv_q     <= 1'b0;
			who_q    <= '0;
			set_en_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						rv_q     <= 1'b0;
						who_q    <= '0;
						set_en_q <= 1'b0;
						dec_q    <= kind ? DEC_CONT : DEC_PROF;
					end
				end
				S_EVAL: begin
					cnt_q <= '0;
					if (tid_bad || tid_blk) begin
						dec_q <= DEC_IGN;
					end else if (last_step) begin
						sum_q <= sum_q - tid_load_x;
						dec_q <= DEC_FIN;
					end
				end
				S_RISE: begin
					if (rising && over && !others_blk) begin
						dec_q    <= DEC_SUSP;
						set_en_q <= !tid_reg;
					end else begin
						set_en_q <= 1'b1;
					end
				end
				S_SRCH: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(MAX_TASKS) && tok[MAX_TASKS].found) begin
						rv_q  <= 1'b1;
						who_q <= 4'(tok[MAX_TASKS].id);
						sum_q <= sum_q - SUM_W'(tok[MAX_TASKS].load)
							+ SUM_W'(tok[MAX_TASKS].lar);
					end
				end
				S_SET: begin
					if (set_en_q)
						sum_q <= sum_q - tid_load_x + SUM_W'(set_val_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			tid_q    <= task_id;
			step_q   <= step;
			amount_q <= amount;
		end
		if (state_q == S_RD2)
			cur_q <= rdata_q;
		if (state_q == S_RD3)
			nxt_q <= rdata_q;
		if (state_q == S_EVAL) begin
			change_q <= {1'b0, nxt_q} - {1'b0, cur_q};
			usage_q  <= last_step ? SUM_W'(amount_q) : usage_max;
		end
		if (state_q == S_RISE)
			set_val_q <= (rising && over && !others_blk) ? cur_q : nxt_q;
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = (state_q == S_DONE);
	assign decision       = dec_q;
	assign resume_valid   = rv_q;
	assign resume_task    = who_q;
	assign expected_total = sum_q;

endmodule

/* design/mas_checker.sv */
// Port-level checks for the memory admission scheduler.
// Bound to memory_admission_scheduler_unit; depends on mas_pkg.
module mas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  decision,
	input logic        resume_valid
);
	import mas_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transfer did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held past one cycle");

	a_resume_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done && resume_valid |-> decision == DEC_CONT || decision == DEC_FIN)
		else $error("release reported on a decision that cannot release");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy still high after done");

endmodule

bind memory_admission_scheduler_unit mas_checker u_mas_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.decision     (decision),
	.resume_valid (resume_valid)
);

/* dv/memory_admission_scheduler_unit_tb.sv */
// Self-checking testbench for memory_admission_scheduler_unit.
// A queue-fed driver, a monitor and a local admission predictor check every result.
// Depends on mas_pkg and the design top.
`timescale 1ns / 100ps

module memory_admission_scheduler_unit_tb;
	import mas_pkg::*;

	localparam int NT = 16;
	localparam int NS = 64;
	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		logic        kind;
		logic [3:0]  tid;
		logic [5:0]  stp;
		logic [31:0] amt;
	} sched_req_t;

	typedef struct {
		dec_t        dec;
		logic        rv;
		logic [3:0]  who;
		logic [35:0] total;
	} sched_ans_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic        kind = 0;
	logic [3:0]  task_id = 0;
	logic [5:0]  step = 0;
	logic [31:0] amount = 0;
	logic        done;
	logic [2:0]  decision;
	logic        resume_valid;
	logic [3:0]  resume_task;
	logic [35:0] expected_total;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 0;
	logic [31:0] cfg_data = 0;

	memory_admission_scheduler_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .task_id(task_id), .step(step), .amount(amount),
		.done(done), .decision(decision), .resume_valid(resume_valid),
		.resume_task(resume_task), .expected_total(expected_total),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial forever #6 clk = ~clk;

	sched_req_t  pending_reqs[$];
	sched_ans_t  expected_answers[$];
	int          n_errors = 0;
	int          n_items = 0;
	int          n_suspends = 0;
	int          n_resumes = 0;
	int          n_cfg = 0;
	int          idle_cycles = 0;
	bit          took = 0;
	int          gap = 0;
	bit          burst = 0;

	// predictor state
	logic [31:0] prof[NS];
	bit          reg_on[NT];
	logic [31:0] load[NT];
	bit          blk[NT];
	longint      thr[NT];
	logic [31:0] lar[NT];
	logic [35:0] load_total = 0;
	logic [31:0] lim = 32'hFFFF_FFFF;
	logic [6:0]  plen = 7'd64;

	// generator state
	int          cursor[NT];
	int          gen_len = 64;

	initial begin
		for (int i = 0; i < NT; i++) begin
			reg_on[i] = 0; load[i] = 0; blk[i] = 0; thr[i] = 0; lar[i] = 0; cursor[i] = 0;
		end
		for (int i = 0; i < NS; i++) prof[i] = 0;
	end

	function automatic void set_load(int t, logic [31:0] v);
		if (reg_on[t])
			load_total = load_total - load[t];
		reg_on[t] = 1;
		load[t] = v;
		load_total = load_total + v;
	endfunction

	function automatic void release_best(longint usage, output bit found, output int who);
		found = 0;
		who = 0;
		for (int t = 0; t < NT; t++)
			if (blk[t] && thr[t] > usage && (!found || thr[t] < thr[who])) begin
				found = 1;
				who = t;
			end
		if (found) begin
			blk[who] = 0;
			set_load(who, lar[who]);
		end
	endfunction

	function automatic sched_ans_t admit(sched_req_t r);
		sched_ans_t  a;
		int          len, t, nb, no, who;
		bit          found, susp;
		logic [31:0] cur, nxt;
		longint      change, usage;
		a.dec = DEC_CONT;
		found = 0;
		who = 0;
		t = r.tid;
		if (r.kind == 1'b0) begin
			prof[r.stp] = r.amt;
			a.dec = DEC_PROF;
		end else if (blk[t]) begin
			a.dec = DEC_IGN;
		end else begin
			len = (plen == 0) ? 1 : (plen > NS) ? NS : plen;
			if (r.stp >= len - 1) begin
				if (reg_on[t]) begin
					load_total = load_total - load[t];
					reg_on[t] = 0;
					load[t] = 0;
				end
				release_best(longint'(r.amt), found, who);
				a.dec = DEC_FIN;
			end else begin
				cur = prof[r.stp];
				nxt = prof[r.stp + 1];
				change = longint'(nxt) - longint'(cur);
				usage = longint'(load_total);
				if (longint'(r.amt) > usage) usage = longint'(r.amt);
				if (change > 0) begin
					susp = (usage + change) >= longint'(lim);
					nb = 0;
					no = 0;
					for (int i = 0; i < NT; i++) begin
						if (blk[i]) nb++;
						if (reg_on[i] && i != t) no++;
					end
					// never suspend when every other running task is already parked
					if (susp && nb == no) susp = 0;
					if (susp) begin
						blk[t] = 1;
						thr[t] = longint'(lim) - change;
						lar[t] = nxt;
						if (!reg_on[t]) set_load(t, cur);
						a.dec = DEC_SUSP;
					end else begin
						set_load(t, nxt);
					end
				end else begin
					release_best(usage, found, who);
					set_load(t, nxt);
				end
			end
		end
		a.rv = found;
		a.who = found ? 4'(who) : 4'd0;
		a.total = load_total;
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		n_errors++;
		$display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	// driver
	always @(posedge clk) took = start && !busy;

	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 0;
		end else if (start && !took) begin
			start <= 1;
		end else if (gap > 0) begin
			gap = gap - 1;
			start <= 0;
		end else if (pending_reqs.size() > 0) begin
			sched_req_t r;
			r = pending_reqs.pop_front();
			kind <= r.kind;
			task_id <= r.tid;
			step <= r.stp;
			amount <= r.amt;
			start <= 1;
			if ($urandom_range(0, 40) == 0) burst = !burst;
			gap = burst ? 0 : $urandom_range(0, 12);
		end else begin
			start <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			bit active;
			active = 0;
			if (cfg_valid && cfg_ready) begin
				active = 1;
				n_cfg++;
				if (cfg_index == CFG_LIMIT) lim = cfg_data;
				else if (cfg_index == CFG_LENGTH) plen = cfg_data[6:0];
			end
			if (start && !busy) begin
				sched_req_t r;
				active = 1;
				r.kind = kind; r.tid = task_id; r.stp = step; r.amt = amount;
				expected_answers.push_back(admit(r));
				n_items++;
			end
			if (done) begin
				active = 1;
				if (expected_answers.size() == 0) begin
					report_mismatch("unexpected result, decision", 64'(decision), 0);
				end else begin
					sched_ans_t e;
					e = expected_answers.pop_front();
					if (e.dec == DEC_SUSP) n_suspends++;
					if (e.rv) n_resumes++;
					if (decision !== e.dec) report_mismatch("decision", 64'(decision), 64'(e.dec));
					if (resume_valid !== e.rv)
						report_mismatch("resume_valid", 64'(resume_valid), 64'(e.rv));
					if (resume_task !== e.who)
						report_mismatch("resume_task", 64'(resume_task), 64'(e.who));
					if (expected_total !== e.total)
						report_mismatch("expected_total", 64'(expected_total), 64'(e.total));
				end
			end
			idle_cycles = active ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("memory_admission_scheduler_unit: mismatch");
				$finish;
			end
		end
	end

	function automatic sched_req_t mk(logic k, int t, int s, logic [31:0] v);
		sched_req_t r;
		r.kind = k; r.tid = 4'(t); r.stp = 6'(s); r.amt = v;
		return r;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_answers.size() > 0 || start)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_phase(logic [31:0] l, logic [6:0] n);
		drain();
		write_reg(CFG_LIMIT, l);
		write_reg(CFG_LENGTH, n);
		gen_len = (n == 0) ? 1 : (n > NS) ? NS : n;
		for (int i = 0; i < NT; i++) cursor[i] = 0;
	endtask

	// mostly tasks walking the profile in order, with some noise and profile rewrites
	task automatic random_items(int n);
		int t, sel;
		logic [31:0] v;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			v = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 600);
			if (sel < 8) begin
				pending_reqs.push_back(mk(0, 0, $urandom_range(0, NS - 1), v));
			end else if (sel < 18) begin
				pending_reqs.push_back(mk(1, $urandom_range(0, NT - 1),
					$urandom_range(0, NS - 1), $urandom()));
			end else begin
				t = $urandom_range(0, 7) + (($urandom_range(0, 3) == 0) ? 8 : 0);
				pending_reqs.push_back(mk(1, t, cursor[t], v));
				cursor[t] = (cursor[t] >= gen_len - 1) ? 0 : cursor[t] + 1;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// every profile entry written before any measurement reads it
		pending_reqs.push_back(mk(0, 0, 0, 32'd0));
		pending_reqs.push_back(mk(0, 0, 1, 32'hFFFF_FFFF));
		pending_reqs.push_back(mk(0, 0, 2, 32'd0));
		for (int i = 3; i < NS; i++)
			pending_reqs.push_back(mk(0, 5, i, $urandom_range(0, 500)));

		// directed: extreme rise and fall, suspension, ignored blocked task, finish
		set_phase(32'hFFFF_FFFF, 7'd64);
		pending_reqs.push_back(mk(1, 1, 5, 32'd0));
		pending_reqs.push_back(mk(1, 0, 0, 32'd0));
		pending_reqs.push_back(mk(1, 0, 0, 32'hFFFF_FFFF));
		pending_reqs.push_back(mk(1, 2, 0, 32'hFFFF_FFFF));
		pending_reqs.push_back(mk(1, 3, 1, 32'hFFFF_FFFF));
		pending_reqs.push_back(mk(1, 15, 63, 32'd0));
		pending_reqs.push_back(mk(1, 1, 62, 32'd0));
		pending_reqs.push_back(mk(1, 4, 2, 32'd7));
		pending_reqs.push_back(mk(0, 0, 63, 32'hFFFF_FFFF));
		pending_reqs.push_back(mk(1, 5, 62, 32'd1));
		pending_reqs.push_back(mk(1, 3, 63, 32'hFFFF_FFFF));
		set_phase(32'd0, 7'd4);
		pending_reqs.push_back(mk(1, 6, 0, 32'd0));
		pending_reqs.push_back(mk(1, 7, 0, 32'd0));
		pending_reqs.push_back(mk(1, 6, 3, 32'd0));
		pending_reqs.push_back(mk(1, 7, 3, 32'd0));

		set_phase(32'd1500, 7'd16);  random_items(120);
		set_phase(32'd3000, 7'd8);   random_items(120);
		set_phase(32'd0, 7'd1);      random_items(60);
		set_phase(32'd800, 7'd64);   random_items(120);
		set_phase(32'd600, 7'd0);    random_items(60);
		set_phase(32'd2500, 7'd127); random_items(130);
		set_phase(32'd1200, 7'd12);  random_items(120);
		set_phase(32'hFFFF_FFFF, 7'd5); random_items(140);
		drain();
		repeat (40) @(posedge clk);

		$display("covered %0d items, %0d register writes, %0d suspensions, %0d resumes",
			n_items, n_cfg, n_suspends, n_resumes);
		if (n_errors == 0 && expected_answers.size() == 0) begin
			$display("memory_admission_scheduler_unit: match");
		end else begin
			$display("%0d errors, %0d results outstanding", n_errors, expected_answers.size());
			$display("memory_admission_scheduler_unit: mismatch");
		end
		$finish;
	end

endmodule
